/* rtl/graph_depth_first_traversal_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the graph traversal block
// Shorthand for clocked assertions on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DEPTH_FIRST_TRAVERSAL_MACROS_SVH
`define GRAPH_DEPTH_FIRST_TRAVERSAL_MACROS_SVH

// condition holds at every clock edge out of reset
`define GDFT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GDFT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/gdft_pkg.sv */
// ----------------------------------------------------------------------------
// gdft_pkg
// Shared types, codes and defaults for the depth-first graph traversal block.
// ----------------------------------------------------------------------------
package gdft_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_DEGREE_DEF   = 8;

  localparam int FIELD_VW  = 6;  // vertex field width on the ports
  localparam int CFG_W     = 7;  // vertex_count register width
  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd64;

  localparam logic FUNC_EDGE     = 1'b0;
  localparam logic FUNC_TRAVERSE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_VISIT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_E_RDA,
    ST_E_RDB,
    ST_E_CHK,
    ST_E_WR2,
    ST_CLR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_NB_REQ,
    ST_NB_CHK,
    ST_VIS_CHK,
    ST_POP_WAIT
  } state_t;

  typedef struct packed {
    logic                func;
    logic [FIELD_VW-1:0] first_vertex;
    logic [FIELD_VW-1:0] second_vertex;
  } cmd_t;

  typedef struct packed {
    kind_t               kind;
    logic [FIELD_VW-1:0] vertex;
    logic                last;
  } result_t;

  // event from the sequencer to the result stage
  typedef struct packed {
    logic                valid;
    logic                flush;  // traversal finished, release held visit as last
    kind_t               kind;
    logic [FIELD_VW-1:0] vertex;
  } ev_t;

endpackage

/* rtl/gdft_ram.sv */
// ----------------------------------------------------------------------------
// gdft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdft_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gdft_seq.sv */
// ----------------------------------------------------------------------------
// gdft_seq
// Sequencer: edge insertion and the stack-based depth-first walk over the
// neighbour, degree, visited and stack memories.
// ----------------------------------------------------------------------------
`include "graph_depth_first_traversal_macros.svh"

module gdft_seq #(
  parameter int MAX_VERTICES = gdft_pkg::MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = gdft_pkg::MAX_DEGREE_DEF,
  parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  gdft_pkg::cmd_t cmd,
  input  logic [NW-1:0]  active_n,
  output logic           busy,
  output gdft_pkg::ev_t  ev
);
  import gdft_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int SW = VW + 2 * DW;

  state_t        state, state_next;
  logic [NW-1:0] scan, scan_next;
  logic [NW-1:0] sp, sp_next;
  logic [VW-1:0] ea, ea_next, eb, eb_next, wv, wv_next;
  logic [DW-1:0] da, da_next, db, db_next;
  logic [VW-1:0] top_v, top_v_next;
  logic [DW-1:0] top_i, top_i_next, top_d, top_d_next;

  // memory ports
  logic [VW-1:0]    vaddr;
  logic             vis_we, vis_wdata, vis_rdata;
  logic [VW-1:0]    vis_waddr;
  logic             deg_we;
  logic [VW-1:0]    deg_waddr;
  logic [DW-1:0]    deg_wdata, deg_rdata;
  logic             nbr_we;
  logic [VW+IW-1:0] nbr_waddr, nbr_raddr;
  logic [VW-1:0]    nbr_wdata, nbr_rdata;
  logic             stk_we;
  logic [VW-1:0]    stk_waddr, stk_raddr;
  logic [SW-1:0]    stk_wdata, stk_rdata;

  gdft_ram #(.W(1), .D(MAX_VERTICES)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vaddr), .rdata(vis_rdata)
  );

  gdft_ram #(.W(DW), .D(MAX_VERTICES)) u_deg (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(vaddr), .rdata(deg_rdata)
  );

  gdft_ram #(.W(VW), .D(MAX_VERTICES * (2 ** IW))) u_nbr (
    .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
    .raddr(nbr_raddr), .rdata(nbr_rdata)
  );

  gdft_ram #(.W(SW), .D(MAX_VERTICES)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      scan  <= '0;
      sp    <= '0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    ea    <= ea_next;
    eb    <= eb_next;
    wv    <= wv_next;
    da    <= da_next;
    db    <= db_next;
    top_v <= top_v_next;
    top_i <= top_i_next;
    top_d <= top_d_next;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    scan_next  = scan;
    sp_next    = sp;
    ea_next    = ea;
    eb_next    = eb;
    wv_next    = wv;
    da_next    = da;
    db_next    = db;
    top_v_next = top_v;
    top_i_next = top_i;
    top_d_next = top_d;

    ev        = '0;
    ev.kind   = KIND_ADDED;
    vaddr     = scan[VW-1:0];
    vis_we    = 1'b0;
    vis_waddr = scan[VW-1:0];
    vis_wdata = 1'b0;
    deg_we    = 1'b0;
    deg_waddr = scan[VW-1:0];
    deg_wdata = '0;
    nbr_we    = 1'b0;
    nbr_waddr = {ea, da[IW-1:0]};
    nbr_wdata = eb;
    nbr_raddr = {top_v, top_i[IW-1:0]};
    stk_we    = 1'b0;
    stk_waddr = VW'(sp - NW'(1));
    stk_wdata = {top_v, top_i, top_d};
    stk_raddr = VW'(sp - NW'(2));

    case (state)
      ST_INIT: begin
        // clear every degree counter once after reset
        deg_we = 1'b1;
        if (scan == NW'(MAX_VERTICES - 1)) begin
          scan_next  = '0;
          state_next = ST_IDLE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (cmd.func == FUNC_TRAVERSE) begin
            scan_next  = '0;
            state_next = ST_CLR;
          end else if (int'(cmd.first_vertex) >= int'(active_n) ||
                       int'(cmd.second_vertex) >= int'(active_n)) begin
            ev.valid = 1'b1;
            ev.kind  = KIND_RANGE;
          end else begin
            ea_next    = VW'(cmd.first_vertex);
            eb_next    = VW'(cmd.second_vertex);
            state_next = ST_E_RDA;
          end
        end
      end
      ST_E_RDA: begin
        vaddr      = ea;
        state_next = ST_E_RDB;
      end
      ST_E_RDB: begin
        vaddr      = eb;
        da_next    = deg_rdata;
        state_next = ST_E_CHK;
      end
      ST_E_CHK: begin
        // self loop needs two free slots in the one list
        if ((ea == eb) ? (int'(da) + 2 > MAX_DEGREE)
                       : (int'(da) >= MAX_DEGREE || int'(deg_rdata) >= MAX_DEGREE)) begin
          ev.valid   = 1'b1;
          ev.kind    = KIND_FULL;
          state_next = ST_IDLE;
        end else begin
          nbr_we     = 1'b1;
          deg_we     = 1'b1;
          deg_waddr  = ea;
          deg_wdata  = da + 1'b1;
          db_next    = (ea == eb) ? da + 1'b1 : deg_rdata;
          state_next = ST_E_WR2;
        end
      end
      ST_E_WR2: begin
        nbr_we     = 1'b1;
        nbr_waddr  = {eb, db[IW-1:0]};
        nbr_wdata  = ea;
        deg_we     = 1'b1;
        deg_waddr  = eb;
        deg_wdata  = db + 1'b1;
        ev.valid   = 1'b1;
        ev.kind    = KIND_ADDED;
        state_next = ST_IDLE;
      end
      ST_CLR: begin
        if (scan >= active_n) begin
          scan_next  = '0;
          state_next = ST_SCAN;
        end else begin
          vis_we    = 1'b1;
          scan_next = scan + 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan >= active_n) begin
          ev.flush   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        scan_next = scan + 1'b1;
        if (vis_rdata) begin
          state_next = ST_SCAN;
        end else begin
          vis_we     = 1'b1;
          vis_wdata  = 1'b1;
          top_v_next = scan[VW-1:0];
          top_i_next = '0;
          top_d_next = deg_rdata;
          sp_next    = NW'(1);
          ev.valid   = 1'b1;
          ev.kind    = KIND_VISIT;
          ev.vertex  = FIELD_VW'(scan[VW-1:0]);
          state_next = ST_NB_REQ;
        end
      end
      ST_NB_REQ: begin
        if (top_i < top_d) begin
          top_i_next = top_i + 1'b1;
          state_next = ST_NB_CHK;
        end else if (sp == NW'(1)) begin
          sp_next    = '0;
          state_next = ST_SCAN;
        end else begin
          // pop: the entry below the top comes back from the stack memory
          sp_next    = sp - 1'b1;
          state_next = ST_POP_WAIT;
        end
      end
      ST_NB_CHK: begin
        wv_next = nbr_rdata;
        vaddr   = nbr_rdata;
        if (int'(nbr_rdata) >= int'(active_n)) begin
          state_next = ST_NB_REQ;
        end else begin
          state_next = ST_VIS_CHK;
        end
      end
      ST_VIS_CHK: begin
        state_next = ST_NB_REQ;
        if (!vis_rdata) begin
          vis_we     = 1'b1;
          vis_waddr  = wv;
          vis_wdata  = 1'b1;
          stk_we     = 1'b1;
          top_v_next = wv;
          top_i_next = '0;
          top_d_next = deg_rdata;
          sp_next    = sp + 1'b1;
          ev.valid   = 1'b1;
          ev.kind    = KIND_VISIT;
          ev.vertex  = FIELD_VW'(wv);
        end
      end
      ST_POP_WAIT: begin
        {top_v_next, top_i_next, top_d_next} = stk_rdata;
        state_next = ST_NB_REQ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `GDFT_ASSERT_ALWAYS(a_sp_bound, int'(sp) <= MAX_VERTICES, "stack pointer past depth")
  `GDFT_ASSERT_IMPLY(a_walk_has_top, state == ST_NB_REQ || state == ST_NB_CHK || state == ST_VIS_CHK || state == ST_POP_WAIT, sp != '0, "walk state with empty stack")
  `GDFT_ASSERT_IMPLY(a_deg_bound, deg_we, int'(deg_wdata) <= MAX_DEGREE, "degree over list capacity")

endmodule

/* rtl/gdft_out.sv */
// ----------------------------------------------------------------------------
// gdft_out
// Result stage: registers results and holds back one visit so that the
// final visit of a traversal can carry the last flag.
// ----------------------------------------------------------------------------
`include "graph_depth_first_traversal_macros.svh"

module gdft_out (
  input  logic              clk,
  input  logic              rst,
  input  gdft_pkg::ev_t     ev,
  output logic              done,
  output gdft_pkg::result_t result
);
  import gdft_pkg::*;

  logic                done_next;
  result_t             result_next;
  logic                pend_valid, pend_valid_next;
  logic [FIELD_VW-1:0] pend_v, pend_v_next;

  always_comb begin
    done_next       = 1'b0;
    result_next     = result;
    pend_valid_next = pend_valid;
    pend_v_next     = pend_v;
    if (ev.valid) begin
      if (ev.kind == KIND_VISIT) begin
        // a new visit releases the held one, not last
        if (pend_valid) begin
          done_next   = 1'b1;
          result_next = '{kind: KIND_VISIT, vertex: pend_v, last: 1'b0};
        end
        pend_valid_next = 1'b1;
        pend_v_next     = ev.vertex;
      end else begin
        done_next   = 1'b1;
        result_next = '{kind: ev.kind, vertex: '0, last: 1'b1};
      end
    end
    if (ev.flush) begin
      pend_valid_next = 1'b0;
      if (pend_valid) begin
        done_next   = 1'b1;
        result_next = '{kind: KIND_VISIT, vertex: pend_v, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      done       <= done_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    pend_v <= pend_v_next;
  end

  `GDFT_ASSERT_IMPLY(a_edge_no_pend, ev.valid && ev.kind != KIND_VISIT, !pend_valid, "edge item while a visit is held")

endmodule

/* rtl/graph_depth_first_traversal.sv */
// Edge item: range check in idle, then degree reads and check; if added, both lists written.
// Traversal item: clears n visited marks, checks each scanned vertex and ends on a scan, and
//   checks each neighbor entry and pops the stack, all through registered-read memories.
// Results are registered the cycle after the step that makes them, at most one a cycle; the
//   receiver cannot stall. Each visit is held until the next visit or the end of the walk.
// After rst all MAX_VERTICES degree entries are swept, one entry a cycle, busy high.
// ----------------------------------------------------------------------------
// graph_depth_first_traversal
// Undirected graph store with an iterative depth-first traversal engine.
// ----------------------------------------------------------------------------
module graph_depth_first_traversal #(
  parameter int MAX_VERTICES = gdft_pkg::MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = gdft_pkg::MAX_DEGREE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  gdft_pkg::cmd_t                 cmd,
  output logic                           done,
  output gdft_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [gdft_pkg::CFG_W-1:0]     cfg_data
);
  import gdft_pkg::*;

  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [CFG_W-1:0] vertex_count;
  logic [NW-1:0]    active_n;
  ev_t              ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  // counts above the vertex capacity act as the capacity
  assign active_n = (int'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                        : NW'(vertex_count);

  gdft_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_DEGREE  (MAX_DEGREE),
    .NW          (NW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .active_n(active_n),
    .busy    (busy),
    .ev      (ev)
  );

  gdft_out u_out (
    .clk   (clk),
    .rst   (rst),
    .ev    (ev),
    .done  (done),
    .result(result)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the depth-first graph block against a predictor of its own: edges
// are added under many vertex counts, including zero and values above the
// vertex limit, and full traversals are compared visit by visit.
// ----------------------------------------------------------------------------
module tb_top;
  import gdft_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;
  localparam int MAXD = MAX_DEGREE_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  graph_depth_first_traversal i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [FIELD_VW-1:0] adj_m [MAXV][MAXD];
  int unsigned deg_m [MAXV];
  bit seen_m [MAXV];
  logic [FIELD_VW-1:0] stk_vertex [MAXV];
  int unsigned stk_next [MAXV];
  int unsigned sp_m;
  logic [CFG_W-1:0] vcount_m = VERTEX_COUNT_RST;
  bit pend_valid;
  logic [FIELD_VW-1:0] pend_vertex;

  result_t due_results [$];
  result_t want;
  int mismatches = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  function automatic int unsigned live_count();
    return (vcount_m > MAXV) ? MAXV : vcount_m;
  endfunction

  function automatic void push_result(kind_t k, logic [FIELD_VW-1:0] v, logic l);
    result_t r;
    r.kind = k;
    r.vertex = v;
    r.last = l;
    due_results = {due_results, r};
  endfunction

  function automatic void add_link(logic [FIELD_VW-1:0] a, logic [FIELD_VW-1:0] b);
    int unsigned n;
    bit full;
    n = live_count();
    if (a >= n || b >= n) begin
      push_result(KIND_RANGE, '0, 1'b1);
      return;
    end
    // a self loop takes two slots of the same list
    if (a == b) full = (deg_m[a] + 2 > MAXD);
    else full = (deg_m[a] >= MAXD) || (deg_m[b] >= MAXD);
    if (full) begin
      push_result(KIND_FULL, '0, 1'b1);
    end else begin
      adj_m[a][deg_m[a]] = b;
      deg_m[a]++;
      adj_m[b][deg_m[b]] = a;
      deg_m[b]++;
      push_result(KIND_ADDED, '0, 1'b1);
    end
  endfunction

  // visits are held back one step so the final one can carry last
  function automatic void mark_visit(logic [FIELD_VW-1:0] v);
    seen_m[v] = 1'b1;
    if (pend_valid) push_result(KIND_VISIT, pend_vertex, 1'b0);
    pend_vertex = v;
    pend_valid = 1'b1;
    stk_vertex[sp_m] = v;
    stk_next[sp_m] = 0;
    sp_m++;
  endfunction

  function automatic void walk_graph();
    int unsigned n;
    int unsigned tos;
    int unsigned idx;
    logic [FIELD_VW-1:0] t;
    logic [FIELD_VW-1:0] w;
    n = live_count();
    pend_valid = 1'b0;
    sp_m = 0;
    for (int s = 0; s < MAXV; s++) seen_m[s] = 1'b0;
    for (int s = 0; s < n; s++) begin
      if (!seen_m[s]) begin
        mark_visit(FIELD_VW'(s));
        while (sp_m > 0) begin
          tos = sp_m - 1;
          t = stk_vertex[tos];
          idx = stk_next[tos];
          if (idx < deg_m[t]) begin
            w = adj_m[t][idx];
            stk_next[tos] = idx + 1;
            // neighbors at or above the live count are skipped
            if (w < n && !seen_m[w] && sp_m < MAXV) mark_visit(w);
          end else begin
            sp_m--;
          end
        end
      end
    end
    if (pend_valid) push_result(KIND_VISIT, pend_vertex, 1'b1);
  endfunction

  // one item per call; start stays high when the next item follows at once
  task automatic send_cmd(input cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c.func == FUNC_TRAVERSE) walk_graph();
    else add_link(c.first_vertex, c.second_vertex);
  endtask

  task automatic send_edge(input int a, input int b);
    cmd_t c;
    c.func = FUNC_EDGE;
    c.first_vertex = FIELD_VW'(a);
    c.second_vertex = FIELD_VW'(b);
    send_cmd(c);
  endtask

  task automatic send_traverse();
    cmd_t c;
    c.func = FUNC_TRAVERSE;
    c.first_vertex = FIELD_VW'($urandom);
    c.second_vertex = FIELD_VW'($urandom);
    send_cmd(c);
  endtask

  // wait out every due result and the tail of the last item
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount_m = v;
  endtask

  task automatic test_empty_traversal();
    send_traverse();
  endtask

  task automatic test_edge_rules();
    send_edge(0, 63);
    send_edge(63, 0);
    send_edge(63, 63);
    send_edge(0, 0);
    // fill vertex 5 with self loops, then probe the full cases
    repeat (3) send_edge(5, 5);
    send_edge(5, 6);
    send_edge(5, 5);
    send_edge(5, 7);
    send_edge(5, 8);
    send_edge(9, 5);
    send_traverse();
  endtask

  task automatic test_shrunk_count();
    write_count(7'd10);
    send_edge(5, 10);  // range wins over full list
    send_edge(10, 0);
    send_traverse();
  endtask

  task automatic test_count_extremes();
    write_count(7'd0);
    send_edge(0, 0);
    send_traverse();
    write_count(7'd127);
    send_edge(63, 62);
    send_edge(1, 62);
    send_traverse();
    write_count(7'd1);
    send_traverse();
    send_edge(0, 1);
    write_count(7'd64);
  endtask

  task automatic test_random_graphs();
    int sent;
    int phase_len;
    int unsigned n;
    int a;
    int b;
    logic [CFG_W-1:0] vc;
    sent = 0;
    while (sent < 420) begin
      case ($urandom_range(0, 9))
        0: vc = CFG_W'($urandom_range(MAXV + 1, 127));
        1: vc = CFG_W'(MAXV);
        2: vc = CFG_W'($urandom_range(0, 3));
        default: vc = CFG_W'($urandom_range(2, MAXV));
      endcase
      write_count(vc);
      gaps_on = ($urandom_range(0, 3) != 0);
      n = live_count();
      phase_len = $urandom_range(15, 40);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_traverse();
        end else begin
          if (n == 0 || $urandom_range(0, 7) == 0) a = $urandom_range(0, 63);
          else a = $urandom_range(0, n - 1);
          if (n == 0 || $urandom_range(0, 7) == 0) b = $urandom_range(0, 63);
          else if ($urandom_range(0, 15) == 0) b = a;
          else b = $urandom_range(0, n - 1);
          send_edge(a, b);
        end
      end
      send_traverse();
      sent += phase_len + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d vertex %0d last %0d",
               result.kind, result.vertex, result.last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, result.kind);
          mismatches++;
        end
        if (result.vertex !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, result.vertex);
          mismatches++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int v = 0; v < MAXV; v++) deg_m[v] = 0;
    sp_m = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_traversal();
    test_edge_rules();
    test_shrunk_count();
    test_count_extremes();
    test_random_graphs();
    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
